/* rtl/mvm_pkg.sv */
`default_nettype none
package mvm_pkg;

  localparam int COL_W           = 10;
  localparam int DATA_W          = 32;
  localparam int DIM_W           = 11;
  localparam int COL_SPAN        = 1024;
  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int DIM_RESET       = 1024;

  typedef enum logic {
    ACT_VECTOR = 1'b0,
    ACT_MATRIX = 1'b1
  } action_t;

  typedef logic [COL_W-1:0]         col_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [DIM_W-1:0]         dim_t;

endpackage
`default_nettype wire

/* rtl/mvm_in_if.sv */
`default_nettype none
interface mvm_in_if import mvm_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  col_t    column;
  data_t   element_value;

  modport source (output valid, action, column, element_value, input ready);
  modport sink   (input valid, action, column, element_value, output ready);
endinterface
`default_nettype wire

/* rtl/mvm_out_if.sv */
`default_nettype none
interface mvm_out_if import mvm_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t row_sum;
  col_t  row_number;

  modport source (output valid, row_sum, row_number, input ready);
  modport sink   (input valid, row_sum, row_number, output ready);
endinterface
`default_nettype wire

/* rtl/mvm_cfg_if.sv */
`default_nettype none
interface mvm_cfg_if import mvm_pkg::*; ();
  logic valid;
  logic ready;
  dim_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/matrix_vector_multiply_core.sv */
// matrix-vector multiply, y = A * x, streaming
// channels: in_ch carries one beat per vector write (action 0, column = index)
//   or per matrix element (action 1), matrix elements in row-major order;
//   out_ch carries one beat per finished row (row_sum, row_number);
//   cfg_ch writes the dimension (0 acts as 1, clamped to the store depth);
//   the user must do so only while the block is idle; the block does not
//   enforce this, and cfg_ch is always ready
// throughput: one input beat per cycle while in_ch is ready; the vector store
//   has one write and one read port, and the multiply-accumulate is pipelined
//   over three stages: the read, product and sum/output registers
// reset: the running sum and row counter clear, the dimension returns to its
//   default, the pipeline empties; the vector store keeps its contents and must
//   be written before use, so there is no clearing pass
// stall: while out_ch is held, the finished row waits in the output register;
//   two further matrix elements fill the pipeline, and non-closing elements
//   keep flowing into the sum; in_ch drops ready only when a second row result
//   is waiting behind the held one
`default_nettype none
module matrix_vector_multiply_core import mvm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  mvm_in_if.sink        in_ch,
  mvm_out_if.source     out_ch,
  mvm_cfg_if.sink       cfg_ch
);

  localparam int   DEPTH     = (MAX_DIM < COL_SPAN) ? MAX_DIM : COL_SPAN;
  localparam int   AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam dim_t DIM_LIMIT = dim_t'(DEPTH);
  localparam dim_t DIM_RST   = (DIM_RESET > DEPTH) ? dim_t'(DEPTH) : dim_t'(DIM_RESET);

  data_t vec_mem [DEPTH];
  data_t rd_data_r;

  dim_t  dim_r, dim_nxt, dim_cfg;
  logic  r_vld_r, r_vld_nxt;
  data_t r_val_r;
  logic  r_last_r;
  logic  p_vld_r, p_vld_nxt;
  data_t product_r;
  logic  p_last_r;
  data_t sum_r, sum_nxt, sum_add;
  col_t  row_r, row_nxt;
  logic  out_vld_r, out_vld_nxt;
  data_t out_sum_r;
  col_t  out_row_r;

  dim_t    col_ext;
  logic    in_fire, vec_wr, rd_load, mat_last;
  logic    r_go, p_go, s1_free;
  logic [AW-1:0] mem_idx;

  assign col_ext  = {1'b0, in_ch.column};
  assign mem_idx  = in_ch.column[AW-1:0];
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign vec_wr   = in_fire && (in_ch.action == ACT_VECTOR) && (col_ext < DIM_LIMIT);
  assign rd_load  = in_fire && (in_ch.action == ACT_MATRIX) && (col_ext < dim_r);
  assign mat_last = (col_ext == dim_r - dim_t'(1));

  assign p_go     = p_vld_r && (!p_last_r || !out_vld_r || out_ch.ready);
  assign s1_free  = !p_vld_r || p_go;
  assign r_go     = r_vld_r && s1_free;

  assign in_ch.ready  = !r_vld_r || s1_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_vld_r;
  assign out_ch.row_sum    = out_sum_r;
  assign out_ch.row_number = out_row_r;

  // dimension in use, clamped at write time
  always_comb begin
    dim_cfg = cfg_ch.data;
    if (dim_cfg == '0) begin
      dim_cfg = dim_t'(1);
    end else if (dim_cfg > DIM_LIMIT) begin
      dim_cfg = DIM_LIMIT;
    end
    dim_nxt = (cfg_ch.valid && cfg_ch.ready) ? dim_cfg : dim_r;
  end

  // vector store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (vec_wr) begin
      vec_mem[mem_idx] <= in_ch.element_value;
    end
    if (rd_load) begin
      rd_data_r <= vec_mem[mem_idx];
    end
  end

  always_comb begin
    r_vld_nxt = r_vld_r;
    if (rd_load) begin
      r_vld_nxt = 1'b1;
    end else if (r_go) begin
      r_vld_nxt = 1'b0;
    end

    p_vld_nxt = p_vld_r;
    if (r_go) begin
      p_vld_nxt = 1'b1;
    end else if (p_go) begin
      p_vld_nxt = 1'b0;
    end

    sum_add = sum_r + product_r;
    sum_nxt = sum_r;
    row_nxt = row_r;
    if (p_go) begin
      if (p_last_r) begin
        sum_nxt = '0;
        if ({1'b0, row_r} + dim_t'(1) >= dim_r) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + col_t'(1);
        end
      end else begin
        sum_nxt = sum_add;
      end
    end

    out_vld_nxt = out_vld_r;
    if (p_go && p_last_r) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r     <= DIM_RST;
      r_vld_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      sum_r     <= '0;
      row_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      dim_r     <= dim_nxt;
      r_vld_r   <= r_vld_nxt;
      p_vld_r   <= p_vld_nxt;
      sum_r     <= sum_nxt;
      row_r     <= row_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_load) begin
      r_val_r  <= in_ch.element_value;
      r_last_r <= mat_last;
    end
    if (r_go) begin
      product_r <= data_t'(r_val_r * rd_data_r);
      p_last_r  <= r_last_r;
    end
    if (p_go && p_last_r) begin
      out_sum_r <= sum_add;
      out_row_r <= row_r;
    end
  end

endmodule
`default_nettype wire

/* rtl/mvm_checker.sv */
`default_nettype none
module mvm_checker import mvm_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire data_t out_row_sum,
  input wire col_t out_row_number
);

  col_t prev_row_r;
  logic have_row_r;
  logic out_fire;

  assign out_fire = out_valid && out_ready;

  // last row number handed out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_row_r <= 1'b0;
      prev_row_r <= '0;
    end else if (out_fire) begin
      have_row_r <= 1'b1;
      prev_row_r <= out_row_number;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_sum)
      && $stable(out_row_number))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_row_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && have_row_r |->
      (out_row_number == prev_row_r + col_t'(1)) || (out_row_number == '0))
    else $error("row number out of sequence");

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_row_sum    (out_ch.row_sum),
  .out_row_number (out_ch.row_number)
);
`default_nettype wire
